FILE: rtl/swsnd_pkg.sv
// Package for the sliding window sender: types, register indexes, reset values
// and the command descriptor that passes from the front end to the back end.
// No dependencies.
package swsnd_pkg;

	localparam int WINDOW_MAX_DEF = 32;

	localparam logic [5:0]  WINDOW_SIZE_RST = 6'd1;
	localparam logic [31:0] CHUNK_COUNT_RST = 32'd0;
	localparam logic [31:0] START_SEQ_RST   = 32'd0;
	localparam logic [15:0] TIMEOUT_RST     = 16'd500;
	localparam logic [15:0] ELAPSED_MAX     = 16'hFFFF;
	localparam logic [1:0]  ACK_TYPE_ACK    = 2'd3;

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_BEGIN = 2'd1,
		REQ_ACK   = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		PKT_START = 2'd0,
		PKT_CLOSE = 2'd1,
		PKT_DATA  = 2'd2
	} pkt_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_START = 3'd1,
		PH_DATA  = 3'd2,
		PH_CLOSE = 3'd3,
		PH_DONE  = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		FS_IDLE  = 3'd0,
		FS_EXEC  = 3'd1,
		FS_SLIDE = 3'd2,
		FS_SERV  = 3'd3,
		FS_PUSH  = 3'd4
	} fstate_t;

	typedef enum logic [1:0] {
		CFG_WINDOW_SIZE = 2'd0,
		CFG_CHUNK_COUNT = 2'd1,
		CFG_START_SEQ   = 2'd2,
		CFG_TIMEOUT     = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic        is_data;
		logic        finished;
		pkt_t        pkt_type;
		logic        send_valid;
		logic [31:0] seq;
	} desc_t;

	localparam int DESC_W = $bits(desc_t);

endpackage

FILE: rtl/sliding_window_sender.sv
// Go-back-N sliding window sender. The front end takes a new input word only once it is
// done with the last one, and waits while the descriptor queue is full. The back end
// takes one descriptor at a time and, on a data pass, scans the window slot by slot.
// An input word is registered, executed by the front end, queued as a descriptor and
// then issued by the back end onto the registered result stream. Reset clears all
// control state at once; no clearing pass is needed.
module sliding_window_sender import swsnd_pkg::*; #(
	parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // ack_type [1:0], ack_seq [33:2], zero pad [39:34]
	input  logic [1:0]  s_tuser,   // req_type [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // pkt_seq [31:0]
	output logic [3:0]  m_tuser,   // send_valid [0], pkt_type [2:1], finished [3]
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int QW = DESC_W + WINDOW_MAX;

	logic                  push_valid;
	logic                  push_ready;
	desc_t                 push_desc;
	logic [WINDOW_MAX-1:0] push_mask;
	logic                  pop_valid;
	logic                  pop_ready;
	logic [QW-1:0]         pop_data;
	desc_t                 pop_desc;
	logic [WINDOW_MAX-1:0] pop_mask;

	assign cfg_ready = 1'b1;
	assign pop_desc  = desc_t'(pop_data[DESC_W-1:0]);
	assign pop_mask  = pop_data[QW-1:DESC_W];

	swsnd_front #(
		.WINDOW_MAX(WINDOW_MAX)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.req_type   (s_tuser),
		.ack_type   (s_tdata[1:0]),
		.ack_seq    (s_tdata[33:2]),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_desc  (push_desc),
		.push_mask  (push_mask)
	);

	swsnd_queue #(
		.DW(QW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({push_mask, push_desc}),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	swsnd_back #(
		.WINDOW_MAX(WINDOW_MAX)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_desc  (pop_desc),
		.pop_mask  (pop_mask),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

FILE: rtl/swsnd_front.sv
// Front end of the sliding window sender: configuration registers, transfer
// state and the sequencer that turns each input word into at most one command descriptor.
// Depends on swsnd_pkg.
module swsnd_front import swsnd_pkg::*; #(
	parameter int WINDOW_MAX = WINDOW_MAX_DEF,
	localparam int CW = $clog2(WINDOW_MAX + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [1:0]            req_type,
	input  logic [1:0]            ack_type,
	input  logic [31:0]           ack_seq,
	input  logic                  cfg_valid,
	input  logic [1:0]            cfg_index,
	input  logic [31:0]           cfg_data,
	output logic                  push_valid,
	input  logic                  push_ready,
	output desc_t                 push_desc,
	output logic [WINDOW_MAX-1:0] push_mask
);

	localparam logic [6:0] WM7 = 7'(WINDOW_MAX);

	logic [5:0]  win_size_q;
	logic [31:0] chunk_count_q;
	logic [31:0] start_seq_q;
	logic [15:0] timeout_q;

	fstate_t                fstate_q, fstate_d;
	phase_t                 phase_q, phase_d;
	logic [31:0]            base_q, base_d;
	logic [WINDOW_MAX-1:0]  sent_q, sent_d;
	logic                   resend_q, resend_d;
	logic [15:0]            elapsed_q, elapsed_d;
	logic [CW-1:0]          shift_q, shift_d;
	logic [CW-1:0]          cnt_q;
	desc_t                  pend_q, pend_d;
	req_t                   req_q;
	logic [1:0]             atype_q;
	logic [31:0]            aseq_q;

	logic [6:0]             ws_ext;
	logic [CW-1:0]          eff_win;
	logic [31:0]            left;
	logic [CW-1:0]          cur_cnt;
	logic [WINDOW_MAX-1:0]  low_mask;
	logic [WINDOW_MAX-1:0]  send_mask;
	logic                   at_end;
	logic [15:0]            limit;
	logic [15:0]            el_inc;
	logic                   expired;
	logic [31:0]            diff;
	logic                   ack_match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_size_q    <= WINDOW_SIZE_RST;
			chunk_count_q <= CHUNK_COUNT_RST;
			start_seq_q   <= START_SEQ_RST;
			timeout_q     <= TIMEOUT_RST;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_WINDOW_SIZE: win_size_q    <= cfg_data[5:0];
				CFG_CHUNK_COUNT: chunk_count_q <= cfg_data;
				CFG_START_SEQ:   start_seq_q   <= cfg_data;
				CFG_TIMEOUT:     timeout_q     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		ws_ext = {1'b0, win_size_q};
		if (ws_ext == 7'd0) begin
			eff_win = CW'(1);
		end else if (ws_ext > WM7) begin
			eff_win = CW'(WINDOW_MAX);
		end else begin
			eff_win = CW'(ws_ext);
		end
		left   = chunk_count_q - base_q;
		at_end = (base_q >= chunk_count_q);
		if (at_end) begin
			cur_cnt = '0;
		end else if (left < 32'(eff_win)) begin
			cur_cnt = CW'(left);
		end else begin
			cur_cnt = eff_win;
		end
		for (int k = 0; k < WINDOW_MAX; k++) begin
			low_mask[k] = (CW'(k) < cur_cnt);
		end
		send_mask = low_mask & (~sent_q | {WINDOW_MAX{resend_q}});
		limit     = (timeout_q == 16'd0) ? 16'd1 : timeout_q;
		el_inc    = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 16'd1;
		expired   = (el_inc >= limit);
		diff      = aseq_q - base_q;
		ack_match = (atype_q == ACK_TYPE_ACK) && (aseq_q == start_seq_q);
	end

	always_comb begin
		fstate_d   = fstate_q;
		phase_d    = phase_q;
		base_d     = base_q;
		sent_d     = sent_q;
		resend_d   = resend_q;
		elapsed_d  = elapsed_q;
		shift_d    = shift_q;
		pend_d     = pend_q;
		s_tready   = 1'b0;
		push_valid = 1'b0;
		push_desc  = pend_q;
		push_mask  = send_mask;
		case (fstate_q)
			FS_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					fstate_d = FS_EXEC;
				end
			end
			FS_EXEC: begin
				fstate_d = FS_IDLE;
				pend_d   = '{is_data: 1'b0, finished: 1'b0, pkt_type: PKT_START,
					send_valid: 1'b1, seq: start_seq_q};
				case (req_q)
					REQ_BEGIN: begin
						phase_d   = PH_START;
						base_d    = '0;
						elapsed_d = '0;
						resend_d  = 1'b1;
						sent_d    = '0;
						fstate_d  = FS_PUSH;
					end
					REQ_TICK: begin
						if (phase_q == PH_DATA) begin
							elapsed_d = el_inc;
							if (expired) begin
								resend_d = 1'b1;
							end
							fstate_d = FS_SERV;
						end else if (phase_q == PH_START || phase_q == PH_CLOSE) begin
							if (expired) begin
								elapsed_d = '0;
								pend_d.pkt_type = (phase_q == PH_START) ? PKT_START : PKT_CLOSE;
								fstate_d  = FS_PUSH;
							end else begin
								elapsed_d = el_inc;
							end
						end
					end
					REQ_ACK: begin
						if (phase_q == PH_START) begin
							if (ack_match) begin
								phase_d   = PH_DATA;
								elapsed_d = '0;
								resend_d  = 1'b1;
								fstate_d  = FS_SERV;
							end
						end else if (phase_q == PH_CLOSE) begin
							if (ack_match) begin
								phase_d  = PH_DONE;
								pend_d   = '{is_data: 1'b0, finished: 1'b1, pkt_type: PKT_START,
									send_valid: 1'b0, seq: 32'd0};
								fstate_d = FS_PUSH;
							end
						end else if (phase_q == PH_DATA) begin
							resend_d = 1'b0;
							fstate_d = FS_SERV;
							if (atype_q == ACK_TYPE_ACK && aseq_q > base_q) begin
								shift_d   = (diff < 32'(cnt_q)) ? CW'(diff) : cnt_q;
								elapsed_d = '0;
								fstate_d  = FS_SLIDE;
							end
						end
					end
					default: ;
				endcase
			end
			FS_SLIDE: begin
				base_d   = base_q + 32'(shift_q);
				sent_d   = sent_q >> shift_q;
				fstate_d = FS_SERV;
			end
			FS_SERV: begin
				if (at_end) begin
					push_valid = 1'b1;
					push_desc  = '{is_data: 1'b0, finished: 1'b0, pkt_type: PKT_CLOSE,
						send_valid: 1'b1, seq: start_seq_q};
					if (push_ready) begin
						phase_d   = PH_CLOSE;
						elapsed_d = '0;
						fstate_d  = FS_IDLE;
					end
				end else if (send_mask == '0) begin
					fstate_d = FS_IDLE;
				end else begin
					push_valid = 1'b1;
					push_desc  = '{is_data: 1'b1, finished: 1'b0, pkt_type: PKT_DATA,
						send_valid: 1'b1, seq: base_q};
					if (push_ready) begin
						sent_d = sent_q | low_mask;
						if (resend_q) begin
							elapsed_d = '0;
							resend_d  = 1'b0;
						end
						fstate_d = FS_IDLE;
					end
				end
			end
			FS_PUSH: begin
				push_valid = 1'b1;
				if (push_ready) begin
					fstate_d = FS_IDLE;
				end
			end
			default: begin
				fstate_d = FS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fstate_q  <= FS_IDLE;
			phase_q   <= PH_IDLE;
			base_q    <= '0;
			sent_q    <= '0;
			resend_q  <= 1'b1;
			elapsed_q <= '0;
			shift_q   <= '0;
			cnt_q     <= '0;
		end else begin
			fstate_q  <= fstate_d;
			phase_q   <= phase_d;
			base_q    <= base_d;
			sent_q    <= sent_d;
			resend_q  <= resend_d;
			elapsed_q <= elapsed_d;
			shift_q   <= shift_d;
			cnt_q     <= cur_cnt;
		end
	end

	always_ff @(posedge clk) begin
		pend_q <= pend_d;
		if (s_tvalid && s_tready) begin
			req_q   <= req_t'(req_type);
			atype_q <= ack_type;
			aseq_q  <= ack_seq;
		end
	end

endmodule

FILE: rtl/swsnd_queue.sv
// Two-entry descriptor queue between the front and back ends of the sender.
// Depends on nothing but its width parameter.
module swsnd_queue #(
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  logic [DW-1:0] push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output logic [DW-1:0] pop_data
);

	logic [DW-1:0] mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: rtl/swsnd_back.sv
// Back end of the sliding window sender: executes one descriptor at a time and
// drives the registered result stream, scanning a data pass one slot a cycle unless the result stream is stalled.
// Depends on swsnd_pkg.
module swsnd_back import swsnd_pkg::*; #(
	parameter int WINDOW_MAX = WINDOW_MAX_DEF,
	localparam int KW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pop_valid,
	output logic                  pop_ready,
	input  desc_t                 pop_desc,
	input  logic [WINDOW_MAX-1:0] pop_mask,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [31:0]           m_tdata,
	output logic [3:0]            m_tuser,
	output logic                  m_tlast
);

	logic                  busy_q;
	desc_t                 cur_q;
	logic [WINDOW_MAX-1:0] rem_q;
	logic [KW-1:0]         k_q;
	logic                  tvalid_q;
	logic [31:0]           tdata_q;
	logic [3:0]            tuser_q;
	logic                  tlast_q;

	logic                  can_load;
	logic [WINDOW_MAX-1:0] k_bit;
	logic [WINDOW_MAX-1:0] rem_rest;
	logic                  bit_set;
	logic                  emit;
	logic                  pop_fire;
	logic                  emit_last;

	assign can_load  = !tvalid_q || m_tready;
	assign k_bit     = WINDOW_MAX'(1) << k_q;
	assign rem_rest  = rem_q & ~k_bit;
	assign bit_set   = (rem_q & k_bit) != '0;
	assign emit      = busy_q && can_load && (!cur_q.is_data || bit_set);
	assign emit_last = !cur_q.is_data || (rem_rest == '0);
	assign pop_ready = !busy_q;
	assign pop_fire  = pop_valid && pop_ready;

	assign m_tvalid = tvalid_q;
	assign m_tdata  = tdata_q;
	assign m_tuser  = tuser_q;
	assign m_tlast  = tlast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			k_q      <= '0;
			tvalid_q <= 1'b0;
		end else begin
			if (pop_fire) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (busy_q) begin
				if (!cur_q.is_data) begin
					if (can_load) begin
						busy_q <= 1'b0;
					end
				end else if (!bit_set || can_load) begin
					k_q <= k_q + KW'(1);
					if (bit_set && rem_rest == '0) begin
						busy_q <= 1'b0;
					end
				end
			end
			if (emit) begin
				tvalid_q <= 1'b1;
			end else if (m_tready) begin
				tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_fire) begin
			cur_q <= pop_desc;
			rem_q <= pop_mask;
		end else if (emit) begin
			rem_q <= rem_rest;
		end
		if (emit) begin
			tdata_q <= cur_q.is_data ? cur_q.seq + 32'(k_q) : cur_q.seq;
			tuser_q <= {cur_q.finished, cur_q.pkt_type, cur_q.send_valid};
			tlast_q <= emit_last;
		end
	end

`ifndef SYNTHESIS
	a_pop_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		pop_fire |-> !busy_q)
		else $error("descriptor taken while another is in progress");

	a_data_pass_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cur_q.is_data) |-> (rem_q != '0))
		else $error("data pass active with no slot left to send");

	a_last_ends_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && emit_last) |=> !busy_q)
		else $error("back end still busy after the final word of a descriptor");

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!tvalid_q || m_tready))
		else $error("result loaded over a word that has not been taken");
`endif

endmodule

FILE: verif/sliding_window_sender_test.sv
`timescale 1ns / 1ps
// Testbench for sliding_window_sender: a directed table, then random transfers,
// with every result word checked against the table or a sender model held here.
// Depends on swsnd_pkg and the sliding_window_sender RTL.
module sliding_window_sender_test;
	import swsnd_pkg::*;

	localparam int SETTLE_CYCLES   = 16;
	localparam int RAND_PHASES     = 12;
	localparam int WORDS_PER_PHASE = 32;

	typedef struct packed {
		logic        send_valid;
		pkt_t        pkt_type;
		logic [31:0] seq;
		logic        last;
		logic        finished;
	} pkt_cmd_t;

	typedef enum logic { ROW_WORD, ROW_REG } row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		cfg_idx_t    ridx;
		req_t        req;
		logic [1:0]  ack_type;
		logic [31:0] val;
		logic        typed;
		logic        quiet;
		pkt_cmd_t    want;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [3:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	int errors = 0;
	bit calm = 1'b0;

	phase_t      sw_phase;
	logic [31:0] sw_base;
	logic [15:0] sw_elapsed;
	bit          sw_resend;
	bit          sw_sent [WINDOW_MAX_DEF];
	logic [5:0]  reg_window;
	logic [31:0] reg_chunks;
	logic [31:0] reg_seq;
	logic [15:0] reg_timeout;

	pkt_cmd_t pending_cmds[$];
	pkt_cmd_t cmd_batch[$];
	dir_row_t dir_tbl[$];

	sliding_window_sender u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	initial begin
		#10ms;
		$display("simulation failed");
		$finish;
	end

	function automatic dir_row_t word_row(req_t r, logic [1:0] at, logic [31:0] v);
		dir_row_t d;
		d = '0;
		d.kind = ROW_WORD;
		d.req = r;
		d.ack_type = at;
		d.val = v;
		return d;
	endfunction

	function automatic dir_row_t quiet_row(req_t r, logic [1:0] at, logic [31:0] v);
		dir_row_t d;
		d = word_row(r, at, v);
		d.typed = 1'b1;
		d.quiet = 1'b1;
		return d;
	endfunction

	function automatic dir_row_t cmd_row(req_t r, logic [1:0] at, logic [31:0] v,
			pkt_t pt, logic [31:0] sq, logic fin);
		dir_row_t d;
		d = word_row(r, at, v);
		d.typed = 1'b1;
		d.want.send_valid = !fin;
		d.want.pkt_type = pt;
		d.want.seq = sq;
		d.want.last = 1'b1;
		d.want.finished = fin;
		return d;
	endfunction

	function automatic dir_row_t reg_row(cfg_idx_t idx, logic [31:0] v);
		dir_row_t d;
		d = '0;
		d.kind = ROW_REG;
		d.ridx = idx;
		d.val = v;
		return d;
	endfunction

	function automatic void sender_reset();
		reg_window = WINDOW_SIZE_RST;
		reg_chunks = CHUNK_COUNT_RST;
		reg_seq = START_SEQ_RST;
		reg_timeout = TIMEOUT_RST;
		sw_phase = PH_IDLE;
		sw_base = 32'd0;
		sw_elapsed = 16'd0;
		sw_resend = 1'b1;
		foreach (sw_sent[k])
			sw_sent[k] = 1'b0;
	endfunction

	function automatic void queue_cmd(logic sv, pkt_t pt, logic [31:0] sq, logic fin);
		pkt_cmd_t c;
		c.send_valid = sv;
		c.pkt_type = pt;
		c.seq = sq;
		c.last = 1'b0;
		c.finished = fin;
		cmd_batch.push_back(c);
	endfunction

	function automatic logic [31:0] eff_window();
		if (reg_window == 6'd0)
			return 32'd1;
		if (reg_window > WINDOW_MAX_DEF)
			return 32'(WINDOW_MAX_DEF);
		return {26'd0, reg_window};
	endfunction

	function automatic logic [31:0] window_span();
		logic [31:0] left;
		if (sw_base >= reg_chunks)
			return 32'd0;
		left = reg_chunks - sw_base;
		return (left < eff_window()) ? left : eff_window();
	endfunction

	function automatic void send_pass();
		logic [31:0] cnt;
		int k;
		if (sw_base >= reg_chunks) begin
			sw_phase = PH_CLOSE;
			sw_elapsed = 16'd0;
			queue_cmd(1'b1, PKT_CLOSE, reg_seq, 1'b0);
			return;
		end
		cnt = window_span();
		for (k = 0; k < cnt; k++) begin
			if (!sw_sent[k] || sw_resend) begin
				sw_sent[k] = 1'b1;
				queue_cmd(1'b1, PKT_DATA, sw_base + 32'(k), 1'b0);
			end
		end
		if (sw_resend) begin
			sw_elapsed = 16'd0;
			sw_resend = 1'b0;
		end
	endfunction

	function automatic void slide_window(logic [31:0] s);
		int k;
		for (k = 0; k < WINDOW_MAX_DEF; k++)
			sw_sent[k] = (k + s < WINDOW_MAX_DEF) ? sw_sent[k + s] : 1'b0;
		sw_base = sw_base + s;
	endfunction

	function automatic void sender_step(req_t r, logic [1:0] at, logic [31:0] sq);
		logic [31:0] lim;
		logic [31:0] nb;
		logic        ack_ok;
		pkt_cmd_t    c;
		cmd_batch.delete();
		ack_ok = (at == ACK_TYPE_ACK);
		case (r)
			REQ_BEGIN: begin
				sw_phase = PH_START;
				sw_base = 32'd0;
				sw_elapsed = 16'd0;
				sw_resend = 1'b1;
				foreach (sw_sent[k])
					sw_sent[k] = 1'b0;
				queue_cmd(1'b1, PKT_START, reg_seq, 1'b0);
			end
			REQ_TICK: begin
				if (sw_phase == PH_START || sw_phase == PH_DATA || sw_phase == PH_CLOSE) begin
					if (sw_elapsed != ELAPSED_MAX)
						sw_elapsed++;
					if (sw_elapsed >= ((reg_timeout == 16'd0) ? 16'd1 : reg_timeout)) begin
						if (sw_phase == PH_DATA) begin
							sw_resend = 1'b1;
						end else begin
							sw_elapsed = 16'd0;
							queue_cmd(1'b1, (sw_phase == PH_START) ? PKT_START : PKT_CLOSE,
								reg_seq, 1'b0);
						end
					end
					if (sw_phase == PH_DATA)
						send_pass();
				end
			end
			REQ_ACK: begin
				if (sw_phase == PH_START) begin
					if (ack_ok && sq == reg_seq) begin
						sw_phase = PH_DATA;
						sw_elapsed = 16'd0;
						sw_resend = 1'b1;
						send_pass();
					end
				end else if (sw_phase == PH_CLOSE) begin
					if (ack_ok && sq == reg_seq) begin
						sw_phase = PH_DONE;
						queue_cmd(1'b0, PKT_START, 32'd0, 1'b1);
					end
				end else if (sw_phase == PH_DATA) begin
					sw_resend = 1'b0;
					if (ack_ok && sq > sw_base) begin
						lim = sw_base + window_span();
						nb = (sq < lim) ? sq : lim;
						if (nb > sw_base)
							slide_window(nb - sw_base);
						sw_elapsed = 16'd0;
					end
					send_pass();
				end
			end
			default: ;
		endcase
		if (cmd_batch.size() > 0) begin
			c = cmd_batch.pop_back();
			c.last = 1'b1;
			cmd_batch.push_back(c);
		end
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		$display("%0t: %s mismatch, got %h, want %h", $time, what, got, want);
	endtask

	task automatic send_word(req_t r, logic [1:0] at, logic [31:0] sq, logic typed,
			logic quiet, pkt_cmd_t want);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 15);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= r;
		s_tdata <= {6'd0, sq, at};
		do @(posedge clk); while (!s_tready);
		sender_step(r, at, sq);
		if (!typed) begin
			foreach (cmd_batch[i])
				pending_cmds.push_back(cmd_batch[i]);
		end else if (!quiet) begin
			pending_cmds.push_back(want);
		end
	endtask

	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_cmds.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_WINDOW_SIZE: reg_window = v[5:0];
			CFG_CHUNK_COUNT: reg_chunks = v;
			CFG_START_SEQ:   reg_seq = v;
			CFG_TIMEOUT:     reg_timeout = v[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int hold_len;
		logic hold;
		m_tready = 1'b0;
		forever begin
			hold = !calm && $urandom_range(0, 3) == 0;
			hold_len = hold ? $urandom_range(1, 15) : $urandom_range(1, 24);
			@(negedge clk);
			m_tready <= !hold;
			repeat (hold_len - 1) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		pkt_cmd_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_cmds.size() == 0) begin
				report("unexpected result word", m_tdata, 32'd0);
			end else begin
				w = pending_cmds.pop_front();
				if (m_tuser[0] !== w.send_valid)
					report("send_valid", 32'(m_tuser[0]), 32'(w.send_valid));
				if (m_tuser[2:1] !== w.pkt_type)
					report("pkt_type", 32'(m_tuser[2:1]), 32'(w.pkt_type));
				if (m_tdata !== w.seq)
					report("pkt_seq", m_tdata, w.seq);
				if (m_tlast !== w.last)
					report("last", 32'(m_tlast), 32'(w.last));
				if (m_tuser[3] !== w.finished)
					report("finished", 32'(m_tuser[3]), 32'(w.finished));
			end
		end
	end

	initial begin
		int p;
		int n;
		int roll;
		req_t r;
		logic [1:0] at;
		logic [31:0] sq;
		logic [31:0] v;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = REQ_TICK;
		cfg_valid = 1'b0;
		cfg_index = CFG_WINDOW_SIZE;
		cfg_data = '0;
		sender_reset();
		dir_tbl = '{
			quiet_row(REQ_TICK, PKT_START, 32'd0),
			quiet_row(REQ_ACK, ACK_TYPE_ACK, 32'd0),
			quiet_row(REQ_NONE, ACK_TYPE_ACK, 32'hFFFF_FFFF),
			cmd_row(REQ_BEGIN, PKT_START, 32'd0, PKT_START, 32'd0, 1'b0),
			quiet_row(REQ_ACK, PKT_DATA, 32'd0),
			quiet_row(REQ_ACK, ACK_TYPE_ACK, 32'd1),
			cmd_row(REQ_ACK, ACK_TYPE_ACK, 32'd0, PKT_CLOSE, 32'd0, 1'b0),
			cmd_row(REQ_ACK, ACK_TYPE_ACK, 32'd0, PKT_START, 32'd0, 1'b1),
			quiet_row(REQ_ACK, ACK_TYPE_ACK, 32'd0),
			reg_row(CFG_WINDOW_SIZE, 32'd63),
			reg_row(CFG_CHUNK_COUNT, 32'd40),
			reg_row(CFG_START_SEQ, 32'hFFFF_FFFF),
			reg_row(CFG_TIMEOUT, 32'd1),
			cmd_row(REQ_BEGIN, PKT_START, 32'd0, PKT_START, 32'hFFFF_FFFF, 1'b0),
			cmd_row(REQ_TICK, PKT_START, 32'd0, PKT_START, 32'hFFFF_FFFF, 1'b0),
			word_row(REQ_ACK, ACK_TYPE_ACK, 32'hFFFF_FFFF),
			word_row(REQ_TICK, PKT_START, 32'd0),
			word_row(REQ_ACK, ACK_TYPE_ACK, 32'd0),
			word_row(REQ_ACK, ACK_TYPE_ACK, 32'hFFFF_FFFF),
			word_row(REQ_ACK, PKT_CLOSE, 32'd40),
			cmd_row(REQ_ACK, ACK_TYPE_ACK, 32'd40, PKT_CLOSE, 32'hFFFF_FFFF, 1'b0),
			cmd_row(REQ_TICK, PKT_START, 32'd0, PKT_CLOSE, 32'hFFFF_FFFF, 1'b0),
			quiet_row(REQ_ACK, ACK_TYPE_ACK, 32'hFFFF_FFFE),
			cmd_row(REQ_ACK, ACK_TYPE_ACK, 32'hFFFF_FFFF, PKT_START, 32'd0, 1'b1),
			cmd_row(REQ_BEGIN, PKT_START, 32'd0, PKT_START, 32'hFFFF_FFFF, 1'b0),
			cmd_row(REQ_BEGIN, PKT_START, 32'd0, PKT_START, 32'hFFFF_FFFF, 1'b0),
			cmd_row(REQ_TICK, PKT_START, 32'd0, PKT_START, 32'hFFFF_FFFF, 1'b0)
		};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_tbl[i]) begin
			if (dir_tbl[i].kind == ROW_REG)
				write_reg(dir_tbl[i].ridx, dir_tbl[i].val);
			else
				send_word(dir_tbl[i].req, dir_tbl[i].ack_type, dir_tbl[i].val,
					dir_tbl[i].typed, dir_tbl[i].quiet, dir_tbl[i].want);
		end

		for (p = 0; p < RAND_PHASES; p++) begin
			calm = (p == RAND_PHASES - 1);
			roll = $urandom_range(0, 9);
			v = $urandom;
			if (roll == 0)
				v[5:0] = 6'd0;
			else if (roll == 1)
				v[5:0] = 6'd63;
			else if (roll == 2)
				v[5:0] = 6'd32;
			else
				v[5:0] = 6'($urandom_range(1, 6));
			write_reg(CFG_WINDOW_SIZE, v);
			roll = $urandom_range(0, 9);
			if (roll == 0)
				v = 32'd0;
			else if (roll == 1)
				v = 32'hFFFF_FFFF;
			else if (roll == 2)
				v = 32'd1;
			else
				v = $urandom_range(2, 30);
			write_reg(CFG_CHUNK_COUNT, v);
			write_reg(CFG_START_SEQ, $urandom);
			roll = $urandom_range(0, 9);
			v = $urandom;
			if (roll == 0)
				v[15:0] = 16'd0;
			else if (roll == 1)
				v[15:0] = 16'hFFFF;
			else
				v[15:0] = 16'($urandom_range(1, 4));
			write_reg(CFG_TIMEOUT, v);

			n = 0;
			while (n < WORDS_PER_PHASE) begin
				roll = $urandom_range(0, 99);
				r = REQ_TICK;
				at = 2'($urandom_range(0, 3));
				sq = $urandom;
				case (sw_phase)
					PH_START: begin
						if (roll < 55) begin
							r = REQ_ACK;
							at = ACK_TYPE_ACK;
							sq = reg_seq;
						end else if (roll < 70) begin
							r = REQ_ACK;
							if (roll < 62)
								sq = reg_seq;
						end else if (roll >= 95) begin
							r = REQ_BEGIN;
						end
					end
					PH_DATA: begin
						if (roll < 50) begin
							r = REQ_ACK;
							at = ACK_TYPE_ACK;
							sq = sw_base + $urandom_range(0, eff_window() + 2);
						end else if (roll < 62) begin
							r = REQ_ACK;
						end else if (roll >= 97) begin
							r = REQ_BEGIN;
						end else if (roll >= 93) begin
							r = REQ_NONE;
						end
					end
					PH_CLOSE: begin
						if (roll < 50) begin
							r = REQ_ACK;
							at = ACK_TYPE_ACK;
							sq = reg_seq;
						end else if (roll < 65) begin
							r = REQ_ACK;
						end else if (roll >= 95) begin
							r = REQ_BEGIN;
						end
					end
					default: begin
						if (roll < 75)
							r = REQ_BEGIN;
						else if (roll < 85)
							r = REQ_ACK;
						else if (roll < 90)
							r = REQ_NONE;
					end
				endcase
				send_word(r, at, sq, 1'b0, 1'b0, '0);
				if (r != REQ_NONE)
					n++;
				if (!calm && $urandom_range(0, 49) == 0)
					settle();
			end
		end

		settle();
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
